// ===== hdl/baro_temp_pressure_compensation_core_macros.svh =====
// assertion macros for the compensation core
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btpc check failed");
`define BTPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btpc check failed");
`else
`define BTPC_ASSERT_SAME(label, ante, cons)
`define BTPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/btpc_pkg.sv =====
`default_nettype none
package btpc_pkg;
	localparam int DIG_W = 32;
	localparam int MUL_LEAVES = 16;

	typedef enum logic [1:0] {
		REG_CALIB0 = 2'd0,
		REG_CALIB1 = 2'd1,
		REG_CALIB2 = 2'd2
	} cfg_reg_t;

	localparam logic signed [23:0] TEMP_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] TEMP_MIN = -24'sh800000;
	localparam logic [24:0] PRES_MAX = 25'h1FFFFFF;
endpackage
`default_nettype wire

// ===== hdl/btpc_mul.sv =====
`default_nettype none
module btpc_mul #(
	parameter int AW = 60,
	parameter int BW = 60
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [AW-1:0]   a,
	input  logic signed [BW-1:0]   b,
	output logic signed [AW+BW-1:0] p
);
	localparam int DW = btpc_pkg::DIG_W;
	localparam int PW = AW + BW;
	localparam int NA = (AW + DW - 1) / DW;
	localparam int NB = (BW + DW - 1) / DW;
	localparam int NP = NA * NB;
	localparam int NL = btpc_pkg::MUL_LEAVES;

	logic signed [2*DW+1:0] pp_s1 [NP];
	logic signed [PW-1:0] leaf [NL];
	logic signed [PW-1:0] sum_s2 [NL/2];
	logic signed [PW-1:0] sum_s3 [NL/4];
	logic signed [PW-1:0] sum_s4 [NL/8];
	logic signed [PW-1:0] sum_s5;

	// digit products, low digits unsigned, top digit signed
	for (genvar i = 0; i < NA; i++) begin : g_a
		logic signed [DW:0] ad;
		if (i == NA - 1) begin : g_top
			assign ad = (DW+1)'($signed(a[AW-1:DW*i]));
		end else begin : g_low
			assign ad = {1'b0, a[DW*i +: DW]};
		end
		for (genvar j = 0; j < NB; j++) begin : g_b
			logic signed [DW:0] bd;
			if (j == NB - 1) begin : g_top
				assign bd = (DW+1)'($signed(b[BW-1:DW*j]));
			end else begin : g_low
				assign bd = {1'b0, b[DW*j +: DW]};
			end
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s1[i*NB+j] <= ad * bd;
				end
			end
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_leaf
		if (k < NP) begin : g_used
			assign leaf[k] = PW'(pp_s1[k]) <<< (DW * ((k / NB) + (k % NB)));
		end else begin : g_zero
			assign leaf[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL/2; k++) sum_s2[k] <= leaf[2*k] + leaf[2*k+1];
			for (int k = 0; k < NL/4; k++) sum_s3[k] <= sum_s2[2*k] + sum_s2[2*k+1];
			for (int k = 0; k < NL/8; k++) sum_s4[k] <= sum_s3[2*k] + sum_s3[2*k+1];
			sum_s5 <= sum_s4[0] + sum_s4[1];
		end
	end

	assign p = sum_s5;
endmodule
`default_nettype wire

// ===== hdl/baro_temp_pressure_compensation_core.sv =====
// Compensates one raw pressure and temperature sample pair per clock; the pipeline
// takes an item every cycle and halts as a whole only while a finished result
// waits at the output. The three calibration words are to be written by the user
// through the config port only while no item is in flight; the block itself does
// not enforce this. Pressure is evaluated exactly as a cubic in Horner form through
// three multipliers built from 33x33 digit products and a registered adder tree.
`default_nettype none
`include "baro_temp_pressure_compensation_core_macros.svh"
module baro_temp_pressure_compensation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        raw_pressure,
	input  logic [23:0]        raw_temperature,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] temperature,
	output logic [24:0]        pressure,
	output logic               saturated
);
	logic [63:0] cw0_q, cw1_q;
	logic [39:0] cw2_q;
	logic [167:0] cal;

	logic [15:0] t1, t2, p5, p6;
	logic signed [7:0] t3, p3, p4, p7, p8, p10, p11;
	logic signed [15:0] p1, p2, p9;
	logic signed [16:0] p1m, p2m;

	logic en;
	logic v_s [1:23];

	logic [23:0] u_s1, u_s2;
	logic signed [24:0] d_s1, us;
	logic signed [41:0] dt2_s2, dt2_s3, up1_s2, up1_s3, up2_s2, up2_s3;
	logic signed [49:0] dd_s2;
	logic signed [32:0] up3_s2, up4_s2, c3_s3, c3_s4;
	logic [47:0] uu_s2;
	logic signed [57:0] ddt3_s3;
	logic [71:0] uuu_s3;
	logic signed [64:0] uup9_s3;
	logic signed [56:0] uup10_s3;
	logic signed [33:0] c2_s3;
	logic signed [80:0] uuup11_s4;
	logic signed [87:0] c0a_s4;

	logic signed [59:0] n_s [4:16];
	logic signed [33:0] c2_s [4:9];
	logic signed [61:0] c1_s [4:15];
	logic signed [87:0] c0_s [5:21];
	logic signed [23:0] t_s [5:22];
	logic ts_s [5:22];

	logic signed [92:0] x, y2_s10;
	logic signed [152:0] z, y1_s16;
	logic signed [212:0] w, s_s22;

	logic signed [60:0] tsum;
	logic signed [28:0] tq;
	logic signed [39:0] rp;

	logic signed [23:0] temp_s23;
	logic [24:0] pres_s23;
	logic sat_s23;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw0_q <= '0;
			cw1_q <= '0;
			cw2_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				btpc_pkg::REG_CALIB0: cw0_q <= cfg_wdata;
				btpc_pkg::REG_CALIB1: cw1_q <= cfg_wdata;
				btpc_pkg::REG_CALIB2: cw2_q <= cfg_wdata[39:0];
				default: ;
			endcase
		end
	end

	assign cal = {cw2_q, cw1_q, cw0_q};
	assign t1  = cal[15:0];
	assign t2  = cal[31:16];
	assign t3  = cal[39:32];
	assign p1  = cal[55:40];
	assign p2  = cal[71:56];
	assign p3  = cal[79:72];
	assign p4  = cal[87:80];
	assign p5  = cal[103:88];
	assign p6  = cal[119:104];
	assign p7  = cal[127:120];
	assign p8  = cal[135:128];
	assign p9  = cal[151:136];
	assign p10 = cal[159:152];
	assign p11 = cal[167:160];
	assign p1m = 17'(p1) - 17'sd16384;
	assign p2m = 17'(p2) - 17'sd16384;

	assign en = !v_s[23] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 23; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= 23; k++) v_s[k] <= v_s[k-1];
		end
	end

	assign us = $signed({1'b0, u_s1});
	assign tsum = 61'(n_s[4]) + 61'sd2147483648;
	assign tq = $signed(tsum[60:32]);
	assign rp = $signed(s_s22[212:173]);

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: raw pressure, and offset of raw temperature from t1 shifted left by 8
			u_s1 <= raw_pressure;
			d_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, t1, 8'h00});
			// s2: first products
			u_s2 <= u_s1;
			dt2_s2 <= d_s1 * $signed({1'b0, t2});
			dd_s2 <= d_s1 * d_s1;
			up1_s2 <= us * p1m;
			up2_s2 <= us * p2m;
			up3_s2 <= us * p3;
			up4_s2 <= us * p4;
			uu_s2 <= u_s1 * u_s1;
			// s3
			dt2_s3 <= dt2_s2;
			ddt3_s3 <= dd_s2 * t3;
			uuu_s3 <= uu_s2 * u_s2;
			uup9_s3 <= $signed({1'b0, uu_s2}) * p9;
			uup10_s3 <= $signed({1'b0, uu_s2}) * p10;
			c3_s3 <= (33'(p8) <<< 22) + up4_s2;
			c2_s3 <= (34'(p7) <<< 24) + 34'(up3_s2);
			up1_s3 <= up1_s2;
			up2_s3 <= up2_s2;
			// s4: temperature numerator and horner coefficients
			n_s[4] <= (60'(dt2_s3) <<< 18) + 60'(ddt3_s3);
			uuup11_s4 <= $signed({1'b0, uuu_s3}) * p11;
			c1_s[4] <= (62'($signed({1'b0, p6})) <<< 42) + (62'(up2_s3) <<< 19)
				+ 62'(uup10_s3);
			c0a_s4 <= (88'($signed({1'b0, p5})) <<< 68) + (88'(up1_s3) <<< 45)
				+ (88'(uup9_s3) <<< 17) + (88'sd1 <<< 56);
			c3_s4 <= c3_s3;
			c2_s[4] <= c2_s3;
			// s5: rounded and clamped temperature, final c0 coefficient
			c0_s[5] <= c0a_s4 + 88'(uuup11_s4);
			if (tq > 29'(btpc_pkg::TEMP_MAX)) begin
				t_s[5] <= btpc_pkg::TEMP_MAX;
				ts_s[5] <= 1'b1;
			end else if (tq < 29'(btpc_pkg::TEMP_MIN)) begin
				t_s[5] <= btpc_pkg::TEMP_MIN;
				ts_s[5] <= 1'b1;
			end else begin
				t_s[5] <= tq[23:0];
				ts_s[5] <= 1'b0;
			end
			// alignment lines
			for (int k = 5; k <= 16; k++) n_s[k] <= n_s[k-1];
			for (int k = 5; k <= 9; k++) c2_s[k] <= c2_s[k-1];
			for (int k = 5; k <= 15; k++) c1_s[k] <= c1_s[k-1];
			for (int k = 6; k <= 21; k++) c0_s[k] <= c0_s[k-1];
			for (int k = 6; k <= 22; k++) begin
				t_s[k] <= t_s[k-1];
				ts_s[k] <= ts_s[k-1];
			end
			// horner steps
			y2_s10 <= x + (93'(c2_s[9]) <<< 53);
			y1_s16 <= z + (153'(c1_s[15]) <<< 85);
			s_s22 <= w + (213'(c0_s[21]) <<< 116);
			// s23: pressure clamp and temperature output register
			temp_s23 <= t_s[22];
			if (rp[39]) begin
				pres_s23 <= '0;
				sat_s23 <= 1'b1;
			end else if (rp > 40'($signed({1'b0, btpc_pkg::PRES_MAX}))) begin
				pres_s23 <= btpc_pkg::PRES_MAX;
				sat_s23 <= 1'b1;
			end else begin
				pres_s23 <= rp[24:0];
				sat_s23 <= ts_s[22];
			end
		end
	end

	btpc_mul #(.AW(60), .BW(33)) u_mul_x (
		.clk(clk), .en(en), .a(n_s[4]), .b(c3_s4), .p(x)
	);

	btpc_mul #(.AW(60), .BW(93)) u_mul_z (
		.clk(clk), .en(en), .a(n_s[10]), .b(y2_s10), .p(z)
	);

	btpc_mul #(.AW(60), .BW(153)) u_mul_w (
		.clk(clk), .en(en), .a(n_s[16]), .b(y1_s16), .p(w[212:0])
	);

	assign out_valid = v_s[23];
	assign temperature = temp_s23;
	assign pressure = pres_s23;
	assign saturated = sat_s23;

	`BTPC_ASSERT_SAME(a_stall_only_on_held_output, !in_ready, out_valid && !out_ready)
	`BTPC_ASSERT_NEXT(a_accept_enters_pipe, in_valid && in_ready, v_s[1])
	`BTPC_ASSERT_NEXT(a_last_stage_reaches_output, v_s[22] && en, out_valid)
endmodule
`default_nettype wire
